// ----- hw/rtl/ctb_pkg.sv -----
// Shared types, request codes and constants for the countdown timer bank.
// Used by ctb_cell, ctb_unit and countdown_timer_bank; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ctb_pkg;

	localparam int NUM_TIMERS_DEF = 32;
	localparam int MAX_REPORTS    = 32;
	localparam int CNT_W          = 32;
	localparam int IDX_W          = 6;
	localparam int REQ_W          = 3;
	localparam int RPT_W          = $clog2(MAX_REPORTS + 1);

	localparam logic signed [CNT_W-1:0] CNT_IDLE = '1;
	localparam logic signed [CNT_W-1:0] CNT_MAX  = {1'b0, {(CNT_W-1){1'b1}}};
	localparam logic signed [CNT_W-1:0] CNT_MIN  = {1'b1, {(CNT_W-1){1'b0}}};

	typedef enum logic [REQ_W-1:0] {
		REQ_TICK    = 3'd0,
		REQ_SWEEP   = 3'd1,
		REQ_START   = 3'd2,
		REQ_RESTART = 3'd3,
		REQ_STOP    = 3'd4,
		REQ_QUERY   = 3'd5,
		REQ_ADD     = 3'd6
	} req_t;

	// One timer as held in a cell of the ring
	typedef struct packed {
		logic                    active;
		logic                    notify;
		logic signed [CNT_W-1:0] count;
	} timer_rec_t;

	// Per-cycle control from the sequencer to the head unit
	typedef struct packed {
		req_t                    req;
		logic                    match;
		logic                    cap;
		logic                    notify;
		logic signed [CNT_W-1:0] amt;
	} unit_ctrl_t;

	// What the head unit reports back for the timer it has just handled
	typedef struct packed {
		logic                    ok;
		logic                    running;
		logic signed [CNT_W-1:0] count;
		logic                    report;
	} unit_res_t;

	localparam timer_rec_t REC_IDLE = '{active: 1'b0, notify: 1'b0, count: CNT_IDLE};

endpackage

`default_nettype wire

// ----- hw/rtl/ctb_cell.sv -----
// One storage cell of the timer ring: holds a single timer record and takes
// its neighbour's record on every shift. Depends on ctb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctb_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 shift,
	input  ctb_pkg::timer_rec_t d,
	output ctb_pkg::timer_rec_t q
);

	ctb_pkg::timer_rec_t rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= ctb_pkg::REC_IDLE;
		end else if (shift) begin
			rec_q <= d;
		end
	end

	assign q = rec_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ctb_unit.sv -----
// Head unit of the timer ring: applies the current request to the record
// leaving the head cell and yields the record to write back at the tail.
// Depends on ctb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctb_unit (
	input  ctb_pkg::timer_rec_t rec_in,
	input  ctb_pkg::unit_ctrl_t ctrl,
	output ctb_pkg::timer_rec_t rec_out,
	output ctb_pkg::unit_res_t  res
);

	logic signed [ctb_pkg::CNT_W:0]   sum;
	logic signed [ctb_pkg::CNT_W-1:0] sat;
	logic                             positive;
	logic                             at_zero;

	always_comb begin
		sum = {rec_in.count[ctb_pkg::CNT_W-1], rec_in.count}
		    + {ctrl.amt[ctb_pkg::CNT_W-1], ctrl.amt};
		// clamp when the extra top bit of the sum disagrees with its sign bit
		if (sum[ctb_pkg::CNT_W] != sum[ctb_pkg::CNT_W-1]) begin
			sat = sum[ctb_pkg::CNT_W] ? ctb_pkg::CNT_MIN : ctb_pkg::CNT_MAX;
		end else begin
			sat = sum[ctb_pkg::CNT_W-1:0];
		end
	end

	assign positive = !rec_in.count[ctb_pkg::CNT_W-1] && (rec_in.count != '0);
	assign at_zero  = (rec_in.count == '0);

	always_comb begin
		rec_out     = rec_in;
		res.ok      = 1'b0;
		res.running = 1'b0;
		res.count   = '0;
		res.report  = 1'b0;
		unique case (ctrl.req)
			ctb_pkg::REQ_TICK: begin
				if (rec_in.active && positive) begin
					rec_out.count = rec_in.count - 1'b1;
				end
			end
			ctb_pkg::REQ_SWEEP: begin
				// free timers at zero until the report limit is reached
				if (rec_in.active && at_zero && !ctrl.cap) begin
					rec_out    = ctb_pkg::REC_IDLE;
					res.report = rec_in.notify;
				end
			end
			ctb_pkg::REQ_START: begin
				if (ctrl.match && !rec_in.active) begin
					rec_out.active = 1'b1;
					rec_out.notify = ctrl.notify;
					rec_out.count  = ctrl.amt;
					res.ok         = 1'b1;
				end
			end
			ctb_pkg::REQ_RESTART: begin
				if (ctrl.match && rec_in.active) begin
					rec_out.count = ctrl.amt;
					res.ok        = 1'b1;
				end
			end
			ctb_pkg::REQ_STOP: begin
				if (ctrl.match && rec_in.active) begin
					rec_out = ctb_pkg::REC_IDLE;
					res.ok  = 1'b1;
				end
			end
			ctb_pkg::REQ_QUERY: begin
				res.count = ctb_pkg::CNT_IDLE;
				if (ctrl.match && rec_in.active) begin
					res.ok      = 1'b1;
					res.running = 1'b1;
					res.count   = rec_in.count;
				end
			end
			ctb_pkg::REQ_ADD: begin
				if (ctrl.match && rec_in.active) begin
					rec_out.count = sat;
					res.ok        = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hw/rtl/countdown_timer_bank.sv -----
// Top level of the countdown timer bank: the ring of timer cells, the head
// unit and the walk sequencer. Depends on ctb_pkg, ctb_cell and ctb_unit.
//
// Each request makes one walk from the start edge until busy falls: the
// timer records circulate once round a ring of NUM_TIMERS cells, one record
// through the single head unit per cycle, and the closing state ST_FIN puts
// out the final result. Results appear on strobe for exactly one cycle
// and cannot be held off; a sweep gives its reports in timer order, at most
// one per cycle during the walk, with last_result on the final one. A new
// request may be started in the cycle in which the final result is shown.
`timescale 1ns / 1ps
`default_nettype none

module countdown_timer_bank #(
	parameter int NUM_TIMERS = ctb_pkg::NUM_TIMERS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	output logic                             busy,
	input  wire  [ctb_pkg::REQ_W-1:0]        req_type,
	input  wire  [ctb_pkg::IDX_W-1:0]        timer_index,
	input  wire  signed [ctb_pkg::CNT_W-1:0] amount,
	input  wire                              notify_on_expiry,
	output logic                             strobe,
	output logic                             ok,
	output logic                             running,
	output logic signed [ctb_pkg::CNT_W-1:0] count_value,
	output logic                             expired_valid,
	output logic [ctb_pkg::IDX_W-1:0]        expired_index,
	output logic                             last_result
);

	localparam int PW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t                           state_q;
	logic [PW-1:0]                    pos_q;
	logic [ctb_pkg::RPT_W-1:0]        rpt_q;
	logic                             have_q;
	ctb_pkg::req_t                    req_q;
	logic [ctb_pkg::IDX_W-1:0]        idx_q;
	logic signed [ctb_pkg::CNT_W-1:0] amt_q;
	logic                             notify_q;

	// held result, shown when the walk ends or a later report displaces it
	logic                             hok_q;
	logic                             hrun_q;
	logic signed [ctb_pkg::CNT_W-1:0] hcnt_q;
	logic                             hev_q;
	logic [ctb_pkg::IDX_W-1:0]        hidx_q;

	logic                             strobe_q;
	logic                             ok_q;
	logic                             run_q;
	logic signed [ctb_pkg::CNT_W-1:0] cnt_q;
	logic                             ev_q;
	logic [ctb_pkg::IDX_W-1:0]        eidx_q;
	logic                             last_q;

	ctb_pkg::timer_rec_t ring [NUM_TIMERS];
	ctb_pkg::timer_rec_t tail_rec;
	ctb_pkg::unit_ctrl_t ctrl;
	ctb_pkg::unit_res_t  res;
	logic                walking;
	logic                accept;
	logic                walk_end;
	logic                emit_mid;

	assign walking  = (state_q == ST_WALK);
	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign walk_end = walking && (pos_q == PW'(NUM_TIMERS - 1));
	assign emit_mid = walking && res.report && have_q;

	// ring: each cell takes its upper neighbour, the top cell takes the unit
	for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
		if (i == NUM_TIMERS - 1) begin : g_tail
			ctb_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.shift (walking),
				.d     (tail_rec),
				.q     (ring[i])
			);
		end else begin : g_body
			ctb_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.shift (walking),
				.d     (ring[i+1]),
				.q     (ring[i])
			);
		end
	end

	always_comb begin
		ctrl.req    = req_q;
		ctrl.match  = (idx_q == ctb_pkg::IDX_W'(pos_q));
		ctrl.cap    = (rpt_q >= ctb_pkg::RPT_W'(ctb_pkg::MAX_REPORTS));
		ctrl.notify = notify_q;
		ctrl.amt    = amt_q;
	end

	ctb_unit u_unit (
		.rec_in (ring[0]),
		.ctrl   (ctrl),
		.rec_out(tail_rec),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pos_q    <= '0;
			rpt_q    <= '0;
			have_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_WALK;
						pos_q   <= '0;
						rpt_q   <= '0;
						have_q  <= 1'b0;
					end
				end
				ST_WALK: begin
					pos_q <= pos_q + 1'b1;
					if (res.report) begin
						have_q <= 1'b1;
						rpt_q  <= rpt_q + 1'b1;
					end
					if (emit_mid) begin
						strobe_q <= 1'b1;
					end
					if (walk_end) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					strobe_q <= 1'b1;
					state_q  <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item capture, held result and output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q    <= ctb_pkg::req_t'(req_type);
			idx_q    <= timer_index;
			amt_q    <= amount;
			notify_q <= notify_on_expiry;
			hok_q    <= 1'b0;
			hrun_q   <= 1'b0;
			hcnt_q   <= (req_type == ctb_pkg::REQ_QUERY) ? ctb_pkg::CNT_IDLE : '0;
			hev_q    <= 1'b0;
			hidx_q   <= '0;
		end else if (walking) begin
			if (res.report) begin
				hev_q  <= 1'b1;
				hidx_q <= ctb_pkg::IDX_W'(pos_q);
			end else if (ctrl.match && req_q != ctb_pkg::REQ_SWEEP
			             && req_q != ctb_pkg::REQ_TICK) begin
				hok_q  <= res.ok;
				hrun_q <= res.running;
				hcnt_q <= res.count;
			end
		end
		if (emit_mid || state_q == ST_FIN) begin
			ok_q   <= hok_q;
			run_q  <= hrun_q;
			cnt_q  <= hcnt_q;
			ev_q   <= hev_q;
			eidx_q <= hidx_q;
			last_q <= (state_q == ST_FIN);
		end
	end

	assign strobe        = strobe_q;
	assign ok            = ok_q;
	assign running       = run_q;
	assign count_value   = cnt_q;
	assign expired_valid = ev_q;
	assign expired_index = eidx_q;
	assign last_result   = last_q;

endmodule

`default_nettype wire
